@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the block pool allocator checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FBPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa same-cycle check failed");

// next-cycle implication, disabled in reset
`define FBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpa next-cycle check failed");

`endif

@@ design/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, codes and widths shared by the block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 256;

   localparam int ADDR_W     = 32;
   localparam int BSIZE_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [BSIZE_W-1:0] ROUND_ADD  = 8'h03;
   localparam logic [BSIZE_W-1:0] ROUND_MASK = 8'hFC;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET  = '0;
   localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RESET = 8'd4;
   localparam logic [COUNT_W-1:0] NUM_BLOCKS_RESET = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BAD_ADDR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE_CHK,
      S_FREE_DIV,
      S_INIT_FILL,
      S_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic free_check;
      logic div_step;
      logic fill_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic init_empty;
      logic chk_fail;
      logic div_last;
      logic fill_last;
   } dp_status_type;

endpackage

@@ design/fbpa_req_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_req_if
// command channel of the block pool allocator
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   logic                              valid;
   logic                              ready;
   logic [fbpa_pkg::CMD_W-1:0]        command;
   logic [fbpa_pkg::ADDR_W-1:0]       block_address;

   modport source (output valid, output command, output block_address, input ready);
   modport sink   (input valid, input command, input block_address, output ready);
endinterface

@@ design/fbpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// result channel of the block pool allocator
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fbpa_pkg::STATUS_W-1:0]     status;
   logic [fbpa_pkg::ADDR_W-1:0]       address;
   logic [fbpa_pkg::COUNT_W-1:0]      free_count;

   modport source (output valid, output status, output address, output free_count,
                   input ready);
   modport sink   (input valid, input status, input address, input free_count,
                   output ready);
endinterface

@@ design/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter  int WIDTH = $clog2(fbpa_pkg::MAX_BLOCKS_DEFAULT + 1),
   parameter  int DEPTH = fbpa_pkg::MAX_BLOCKS_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl
// sequencer for allocate, free and init, and owner of the result valid
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  fbpa_pkg::cmd_type       req_command,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  fbpa_pkg::dp_status_type status,
   output fbpa_pkg::ctrl_cmd_type  cmd
);

   fbpa_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      // result register can take a new item this cycle
      out_free  = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         fbpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_command)
                  fbpa_pkg::CMD_FREE: state_in = fbpa_pkg::S_FREE_CHK;
                  fbpa_pkg::CMD_INIT: begin
                     state_in = status.init_empty ? fbpa_pkg::S_COMMIT
                                                  : fbpa_pkg::S_INIT_FILL;
                  end
                  default: state_in = fbpa_pkg::S_COMMIT;
               endcase
            end
         end
         fbpa_pkg::S_FREE_CHK: begin
            cmd.free_check = 1'b1;
            state_in = status.chk_fail ? fbpa_pkg::S_COMMIT : fbpa_pkg::S_FREE_DIV;
         end
         fbpa_pkg::S_FREE_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = fbpa_pkg::S_COMMIT;
            end
         end
         fbpa_pkg::S_INIT_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = fbpa_pkg::S_COMMIT;
            end
         end
         fbpa_pkg::S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = fbpa_pkg::S_IDLE;
            end
         end
         default: state_in = fbpa_pkg::S_IDLE;
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/fbpa_datapath.sv @@
// ----------------------------------------------------------------------------
// fbpa_datapath
// configuration, free list head and count, link store, address divider and
// result register
// ----------------------------------------------------------------------------
module fbpa_datapath #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  fbpa_pkg::cmd_type                   req_command,
   input  logic [fbpa_pkg::ADDR_W-1:0]         req_block_address,
   input  fbpa_pkg::ctrl_cmd_type              cmd,
   output fbpa_pkg::dp_status_type             status,
   output fbpa_pkg::status_type                rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]         rsp_address,
   output logic [fbpa_pkg::COUNT_W-1:0]        rsp_free_count
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int LW = $clog2(MAX_BLOCKS + 1);
   localparam int BW = fbpa_pkg::BSIZE_W;
   localparam int DW = AW + BW;
   localparam int PW = LW + BW;
   localparam int XW = fbpa_pkg::ADDR_W;
   localparam logic [LW-1:0] EMPTY_MARK = LW'(MAX_BLOCKS);

   // configuration, takes effect at init
   logic [XW-1:0]                    cfg_base_ff;
   logic [BW-1:0]                    cfg_bsize_ff;
   logic [fbpa_pkg::COUNT_W-1:0]     cfg_nblk_ff;

   // live pool state
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] count_ff, count_in;
   logic [LW-1:0] live_n_ff;
   logic [BW-1:0] rsize_ff;
   logic [XW-1:0] live_base_ff;
   logic [DW-1:0] span_ff;

   // per-item working registers
   fbpa_pkg::cmd_type    op_ff;
   fbpa_pkg::status_type st_ff;
   logic [XW-1:0]        addr_ff;
   logic [PW-1:0]        prod_ff;
   logic [DW-1:0]        rem_ff;
   logic [DW-1:0]        dvs_ff;
   logic [AW-1:0]        quo_ff;
   logic [LW-1:0]        seq_ff;

   fbpa_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [XW-1:0]                rsp_address_ff, rsp_address_in;
   logic [fbpa_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [BW-1:0] rounded;
   logic [LW-1:0] init_n;
   logic [PW-1:0] init_span;
   logic          init_go;
   logic [XW-1:0] off;
   logic          full, bad, alloc_ok, ge, free_ok;
   logic [LW-1:0] seq_nx, fill_link;
   logic          fill_last;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr;
   logic [LW-1:0] ram_wr_data, ram_rd_data;

   always_comb begin
      rounded   = (cfg_bsize_ff + fbpa_pkg::ROUND_ADD) & fbpa_pkg::ROUND_MASK;
      init_n    = (int'(cfg_nblk_ff) > MAX_BLOCKS) ? EMPTY_MARK : LW'(cfg_nblk_ff);
      init_span = PW'(init_n) * PW'(rounded);
      init_go   = cmd.accept && (req_command == fbpa_pkg::CMD_INIT);

      off  = addr_ff - live_base_ff;
      full = (count_ff >= live_n_ff);
      // past the span covers both the last-block bound and the index bound
      bad  = (addr_ff == '0) || (rsize_ff == '0) || (addr_ff < live_base_ff) ||
             (off >= XW'(span_ff));
      alloc_ok = (count_ff != '0) && (head_ff < EMPTY_MARK);

      ge      = (rem_ff >= dvs_ff);
      free_ok = (st_ff == fbpa_pkg::ST_OK) && (rem_ff == '0);

      seq_nx    = seq_ff + 1'b1;
      fill_last = (seq_nx >= live_n_ff);
      fill_link = fill_last ? EMPTY_MARK : seq_nx;

      status.init_empty = (cfg_nblk_ff == '0);
      status.chk_fail   = full || bad;
      status.div_last   = (seq_ff == LW'(AW - 1));
      status.fill_last  = fill_last;
   end

   // head, count and result for the item being finished
   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      rsp_status_in  = fbpa_pkg::ST_OK;
      rsp_address_in = '0;
      if (init_go) begin
         head_in  = (init_n == '0) ? EMPTY_MARK : '0;
         count_in = init_n;
      end
      if (cmd.commit) begin
         case (op_ff)
            fbpa_pkg::CMD_ALLOC: begin
               if (st_ff == fbpa_pkg::ST_OK) begin
                  head_in        = ram_rd_data;
                  count_in       = count_ff - 1'b1;
                  rsp_address_in = live_base_ff + XW'(prod_ff);
               end else begin
                  rsp_status_in = st_ff;
               end
            end
            fbpa_pkg::CMD_FREE: begin
               if (free_ok) begin
                  head_in  = LW'(quo_ff);
                  count_in = count_ff + 1'b1;
               end else if (st_ff == fbpa_pkg::ST_OK) begin
                  // offset not a whole number of blocks
                  rsp_status_in = fbpa_pkg::ST_BAD_ADDR;
               end else begin
                  rsp_status_in = st_ff;
               end
            end
            default: begin
               rsp_status_in = fbpa_pkg::ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      ram_rd_en   = cmd.accept && (req_command == fbpa_pkg::CMD_ALLOC);
      ram_wr_en   = cmd.fill_step ||
                    (cmd.commit && (op_ff == fbpa_pkg::CMD_FREE) && free_ok);
      ram_wr_addr = cmd.fill_step ? seq_ff[AW-1:0] : quo_ff;
      ram_wr_data = cmd.fill_step ? fill_link : head_ff;
   end

   fbpa_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff  <= fbpa_pkg::POOL_BASE_RESET;
         cfg_bsize_ff <= fbpa_pkg::BLOCK_SIZE_RESET;
         cfg_nblk_ff  <= fbpa_pkg::NUM_BLOCKS_RESET;
         head_ff      <= EMPTY_MARK;
         count_ff     <= '0;
         live_n_ff    <= '0;
         rsize_ff     <= fbpa_pkg::BLOCK_SIZE_RESET;
         live_base_ff <= '0;
         span_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               fbpa_pkg::CSR_POOL_BASE:  cfg_base_ff  <= csr_write_data;
               fbpa_pkg::CSR_BLOCK_SIZE: cfg_bsize_ff <= csr_write_data[BW-1:0];
               fbpa_pkg::CSR_NUM_BLOCKS: begin
                  cfg_nblk_ff <= csr_write_data[fbpa_pkg::COUNT_W-1:0];
               end
               default: ;
            endcase
         end
         if (init_go) begin
            rsize_ff     <= rounded;
            live_base_ff <= cfg_base_ff;
            live_n_ff    <= init_n;
            span_ff      <= DW'(init_span);
         end
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_command;
         addr_ff <= req_block_address;
         st_ff   <= alloc_ok ? fbpa_pkg::ST_OK : fbpa_pkg::ST_EMPTY;
         prod_ff <= PW'(head_ff) * PW'(rsize_ff);
         seq_ff  <= '0;
      end
      if (cmd.free_check) begin
         if (full) begin
            st_ff <= fbpa_pkg::ST_FULL;
         end else if (bad) begin
            st_ff <= fbpa_pkg::ST_BAD_ADDR;
         end else begin
            st_ff <= fbpa_pkg::ST_OK;
         end
         rem_ff <= DW'(off);
         dvs_ff <= DW'(rsize_ff) << (AW - 1);
         quo_ff <= '0;
         seq_ff <= '0;
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         rem_ff <= ge ? (rem_ff - dvs_ff) : rem_ff;
         dvs_ff <= dvs_ff >> 1;
         quo_ff <= AW'({quo_ff, ge});
         seq_ff <= seq_nx;
      end
      if (cmd.fill_step) begin
         seq_ff <= seq_nx;
      end
      if (cmd.commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_address_ff <= rsp_address_in;
         rsp_count_ff   <= fbpa_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_free_count = rsp_count_ff;

endmodule

@@ design/fixed_block_pool_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit: fixed-size block pool allocator, one item at a time
// allocate and unused command go straight to the result; init writes n links (n blocks, one
// link write a cycle); free is refused early or else runs the bit-serial divider
// a new item is taken the cycle after the result is loaded into the output register
// synchronous reset: pool empty until init, link store not cleared, registers at defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_block_pool_allocator_unit #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   fbpa_req_if.sink                            req_chan,
   fbpa_rsp_if.source                          rsp_chan
);

   fbpa_pkg::ctrl_cmd_type  cmd;
   fbpa_pkg::dp_status_type status;
   fbpa_pkg::cmd_type       req_command;
   fbpa_pkg::status_type    rsp_status;
   logic                    req_ready;
   logic                    rsp_valid;

   assign req_command = fbpa_pkg::cmd_type'(req_chan.command);

   fbpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_command       (req_command),
      .req_block_address (req_chan.block_address),
      .cmd               (cmd),
      .status            (status),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_chan.address),
      .rsp_free_count    (rsp_chan.free_count)
   );

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.status = rsp_status;

   // a result is never loaded over one still waiting
   `FBPA_ASSERT_SAME(a_commit_slot_free, clock, reset, cmd.commit && rsp_chan.valid, rsp_chan.ready)
   // accepting and finishing never overlap
   `FBPA_ASSERT_SAME(a_accept_not_commit, clock, reset, cmd.accept, !cmd.commit)
   // one item in flight: no second accept straight after the first
   `FBPA_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_chan.valid && req_ready, !req_ready)
   // a finished item always shows on the result channel
   `FBPA_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_chan.valid)

endmodule
